[hw/rtl/jldv_pkg.sv]
// ----------------------------------------------------------------------------
// jldv_pkg
// Shared types and constants of the jerk-limited braking velocity block.
// ----------------------------------------------------------------------------
package jldv_pkg;

  // saturation bound of internal Q values
  localparam logic signed [63:0] SatLim = 64'sh4000_0000_0000_0000;

  localparam logic [0:0] RegJerk  = 1'b0;
  localparam logic [0:0] RegAccel = 1'b1;

  localparam logic [1:0] PhaseBehind  = 2'd0;
  localparam logic [1:0] PhaseJerk    = 2'd1;
  localparam logic [1:0] PhaseAccel   = 2'd2;
  localparam logic [1:0] PhaseStopped = 2'd3;

  localparam logic [1:0] ErrOk       = 2'd0;
  localparam logic [1:0] ErrPosLimit = 2'd1;
  localparam logic [1:0] ErrRange    = 2'd2;

  // request to a two-operand arithmetic unit
  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } op_req_t;

  // response of a two-operand arithmetic unit
  typedef struct packed {
    logic               done;
    logic signed [63:0] value;
  } op_rsp_t;

endpackage

[hw/rtl/jldv_mul.sv]
// ----------------------------------------------------------------------------
// jldv_mul
// Saturating signed Q multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module jldv_mul import jldv_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  op_req_t req,
  output op_rsp_t rsp
);

  logic [63:0]        ma_r, mb_r;
  logic               neg_r;
  logic [1:0]         cnt_r;
  logic               busy_r, fin_r, done_r;
  logic [127:0]       acc_r;
  logic signed [63:0] res_r;

  logic [31:0]  ha, hb;
  logic [63:0]  pp;
  logic [6:0]   sh;
  logic [63:0]  rq, mag;
  logic         sat;

  assign ha  = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign hb  = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp  = ha * hb;
  assign sh  = {cnt_r[1] & cnt_r[0], cnt_r[1] ^ cnt_r[0], 5'd0};
  assign rq  = acc_r[FRAC_BITS +: 64];
  assign sat = (|acc_r[127:FRAC_BITS+64]) || (rq > 64'(SatLim));
  assign mag = sat ? 64'(SatLim) : rq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (req.start) begin
        ma_r   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
        mb_r   <= req.b[63] ? 64'(-req.b) : 64'(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_r + ({64'd0, pp} << sh);
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        done_r <= 1'b1;
        res_r  <= neg_r ? -$signed(mag) : $signed(mag);
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

[hw/rtl/jldv_div.sv]
// ----------------------------------------------------------------------------
// jldv_div
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module jldv_div import jldv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  op_req_t req,
  output op_rsp_t rsp
);

  logic [63:0]        dvd_r, dvs_r;
  logic [63:0]        rem_r;
  logic               neg_r;
  logic [5:0]         cnt_r;
  logic               busy_r, done_r;
  logic signed [63:0] res_r;

  logic [64:0] rem_sh, diff;
  logic        qbit;

  assign rem_sh = {rem_r, dvd_r[63]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign qbit   = !diff[64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        dvd_r  <= req.a[63] ? 64'(-req.a) : 64'(req.a);
        dvs_r  <= req.b[63] ? 64'(-req.b) : 64'(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= qbit ? diff[63:0] : rem_sh[63:0];
        dvd_r <= {dvd_r[62:0], qbit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= neg_r ? -$signed({dvd_r[62:0], qbit}) : $signed({dvd_r[62:0], qbit});
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

// ----------------------------------------------------------------------------
// jldv_div6
// Signed 64-bit divide by six, truncating, one byte of quotient per cycle.
// ----------------------------------------------------------------------------
module jldv_div6 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] x,
  output logic               done,
  output logic signed [63:0] quot
);

  logic [63:0]        dvd_r;
  logic [2:0]         rem_r;
  logic               neg_r;
  logic [2:0]         cnt_r;
  logic               busy_r, done_r;
  logic signed [63:0] res_r;

  logic [7:0] qbyte;
  logic [2:0] rem_nxt;
  logic [3:0] part;

  // eight compare-and-subtract steps against six, top byte first
  always_comb begin
    rem_nxt = rem_r;
    part    = '0;
    qbyte   = '0;
    for (int i = 7; i >= 0; i--) begin
      part     = {rem_nxt, dvd_r[56 + i]};
      qbyte[i] = part >= 4'd6;
      rem_nxt  = qbyte[i] ? 3'(part - 4'd6) : part[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= x[63] ? 64'(-x) : 64'(x);
        neg_r  <= x[63];
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[55:0], qbyte};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= neg_r ? -$signed({dvd_r[55:0], qbyte}) : $signed({dvd_r[55:0], qbyte});
        end
      end
    end
  end

  assign done = done_r;
  assign quot = res_r;

endmodule

[hw/rtl/jldv_sqrt.sv]
// ----------------------------------------------------------------------------
// jldv_sqrt
// Floored integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module jldv_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x_r, r_r, bit_r;
  logic        busy_r, done_r;
  logic [63:0] trial;
  logic        take;

  assign trial = r_r + bit_r;
  assign take  = x_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= x;
        r_r    <= '0;
        bit_r  <= 64'd1 << 62;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (take) begin
          x_r <= x_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[31:0];

endmodule

[hw/rtl/jerk_limited_decel_velocity.sv]
// ----------------------------------------------------------------------------
// jerk_limited_decel_velocity
// Velocity reached at a target distance under a jerk-limited braking profile.
// ----------------------------------------------------------------------------
// channel  dir  ports                       contents
// in       in   in_tvalid/tready/tdata      start_accel, start_velocity, target_distance
// out      out  out_tvalid/tready/tdata/tuser reached_velocity; phase_code, error_code
// cfg      in   cfg_we/cfg_addr/cfg_wdata   0 jerk_limit, 1 accel_limit
//
// One word at a time; in_tready is high only while the sequencer is idle.
// A distance evaluation takes five multiplies, a divide by six and one compare
// step; the phase time costs a divide. The worst item bisects to the iteration
// cap of MAX_ITER; the constant-deceleration path includes a square root.
// A finished word waits in the output register while the next word is taken.
// Reset is synchronous; both limits return to -1.0.
// ----------------------------------------------------------------------------
module jerk_limited_decel_velocity import jldv_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_ITER  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // start_accel, start_velocity, target_distance
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // reached_velocity
  output logic [3:0]  out_tuser,  // phase_code, error_code
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int EpsRaw = ((1 << FRAC_BITS) + 50000) / 100000;
  localparam logic signed [63:0] EpsS    = 64'((EpsRaw < 1) ? 1 : EpsRaw);
  localparam logic signed [63:0] DiscMax = 64'sd1 <<< (62 - FRAC_BITS);
  localparam logic signed [64:0] LimW    = 65'(SatLim);
  localparam int IterW = $clog2(MAX_ITER + 1);
  localparam logic [IterW-1:0] IterMax = IterW'(MAX_ITER);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_DIVT, S_D_T2, S_D_T3, S_D_JT3, S_D_DIV6, S_D_AT2, S_D_VT,
    S_D_RET, S_BIS, S_V_T2, S_V_JT2, S_V_AT, S_V_RET, S_DS1, S_DS2, S_DS3,
    S_SQRT, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    C_DCJ, C_F0, C_FT, C_MID, C_VB, C_V1
  } ctx_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > LimW) return SatLim;
    else if (s < -LimW) return -SatLim;
    else return s[63:0];
  endfunction

  function automatic logic signed [63:0] half(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + {63'd0, x[63]};
    return y >>> 1;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    else if (x < -64'sd2147483648) return 32'h8000_0000;
    else return x[31:0];
  endfunction

  function automatic logic signed [63:0] ext(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  state_t             state_r;
  ctx_t               ctx_r;
  logic               op_wait_r;
  logic [31:0]        jerk_r, accel_r;
  logic [31:0]        a0_r, v0_r, l_r;
  logic [31:0]        tcj_r, t_r, lo_r, up_r;
  logic signed [63:0] t2_r, t3_r, s_r, fx_r, dacc_r, v1_r;
  logic [IterW-1:0]   iter_r;
  logic [31:0]        res_vel_r;
  logic [1:0]         res_ph_r, res_err_r;
  logic               out_valid_r;
  logic [31:0]        out_vel_r;
  logic [1:0]         out_ph_r, out_err_r;

  op_req_t mul_req, div_req;
  op_rsp_t mul_rsp, div_rsp;
  logic    sq_start, sq_done;
  logic [31:0] sq_root;
  logic    d6_start, d6_done;
  logic signed [63:0] d6_quot;

  logic        mul_st, div_st, d6_st, op_st, op_done, op_fire;
  logic [32:0] num;
  logic signed [63:0] num_sh;
  logic [32:0] mid_sum, mid_rnd;
  logic signed [63:0] neg_d, fx_new, v_new, disc_new;

  assign mul_st = (state_r == S_D_T2) || (state_r == S_D_T3) || (state_r == S_D_JT3) ||
                  (state_r == S_D_AT2) || (state_r == S_D_VT) || (state_r == S_V_T2) ||
                  (state_r == S_V_JT2) || (state_r == S_V_AT) || (state_r == S_DS1) ||
                  (state_r == S_DS2);
  assign div_st = (state_r == S_DIVT);
  assign d6_st  = (state_r == S_D_DIV6);
  assign op_st  = mul_st || div_st || d6_st || (state_r == S_SQRT);
  assign op_done = mul_st ? mul_rsp.done :
                   (div_st ? div_rsp.done : (d6_st ? d6_done : sq_done));
  assign op_fire = op_wait_r && op_done;

  assign num     = {accel_r[31], accel_r} - {a0_r[31], a0_r};
  assign num_sh  = $signed({{31{num[32]}}, num}) <<< FRAC_BITS;
  assign mid_sum = {lo_r[31], lo_r} + {up_r[31], up_r};
  assign mid_rnd = mid_sum + {32'd0, mid_sum[32]};
  assign neg_d   = (ctx_r == C_DCJ) ? 64'sd0 : -ext(l_r);
  assign fx_new  = sadd(sadd(s_r, mul_rsp.value), neg_d);
  assign v_new   = sadd(sadd(s_r, mul_rsp.value), ext(v0_r));
  assign disc_new = sadd(s_r, mul_rsp.value);

  always_comb begin
    mul_req.start = mul_st && !op_wait_r;
    mul_req.a     = ext(t_r);
    mul_req.b     = ext(t_r);
    unique case (state_r)
      S_D_T3:  begin mul_req.a = t2_r;          mul_req.b = ext(t_r); end
      S_D_JT3: begin mul_req.a = ext(jerk_r);   mul_req.b = t3_r;     end
      S_D_AT2: begin mul_req.a = ext(a0_r);     mul_req.b = t2_r;     end
      S_D_VT:  begin mul_req.a = ext(v0_r);     mul_req.b = ext(t_r); end
      S_V_JT2: begin mul_req.a = ext(jerk_r);   mul_req.b = t2_r;     end
      S_V_AT:  begin mul_req.a = ext(a0_r);     mul_req.b = ext(t_r); end
      S_DS1:   begin
        mul_req.a = {{31{accel_r[31]}}, accel_r, 1'b0};
        mul_req.b = dacc_r;
      end
      S_DS2:   begin mul_req.a = v1_r;          mul_req.b = v1_r;     end
      default: begin mul_req.a = ext(t_r);      mul_req.b = ext(t_r); end
    endcase
  end

  always_comb begin
    div_req.start = div_st && !op_wait_r;
    div_req.a     = num_sh;
    div_req.b     = ext(jerk_r);
  end

  assign d6_start = d6_st && !op_wait_r;
  assign sq_start = (state_r == S_SQRT) && !op_wait_r;

  jldv_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp)
  );

  jldv_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp)
  );

  jldv_div6 u_div6 (
    .clk(clk), .rst_n(rst_n), .start(d6_start), .x(s_r), .done(d6_done), .quot(d6_quot)
  );

  jldv_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .x(64'(s_r) << FRAC_BITS),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctx_r       <= C_DCJ;
      op_wait_r   <= 1'b0;
      out_valid_r <= 1'b0;
      jerk_r      <= 32'(-(1 << FRAC_BITS));
      accel_r     <= 32'(-(1 << FRAC_BITS));
    end else begin
      if (cfg_we) begin
        if (cfg_addr == RegJerk) jerk_r <= cfg_wdata;
        if (cfg_addr == RegAccel) accel_r <= cfg_wdata;
      end
      if (state_r == S_FIN && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (op_st) begin
        if (!op_wait_r) op_wait_r <= 1'b1;
        else if (op_done) op_wait_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            a0_r    <= in_tdata[31:0];
            v0_r    <= in_tdata[63:32];
            l_r     <= in_tdata[95:64];
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if ($signed(jerk_r) > 0 || $signed(accel_r) > 0) begin
            res_vel_r <= '0; res_ph_r <= PhaseBehind; res_err_r <= ErrPosLimit;
            state_r   <= S_FIN;
          end else if ($signed(l_r) <= 0) begin
            res_vel_r <= v0_r; res_ph_r <= PhaseBehind; res_err_r <= ErrOk;
            state_r   <= S_FIN;
          end else if (jerk_r == 32'd0) begin
            // zero jerk: phase time saturates by the sign of the accel gap
            if (num == 33'd0) begin
              tcj_r <= '0; t_r <= '0;
            end else if (num[32]) begin
              tcj_r <= 32'h7fff_ffff; t_r <= 32'h7fff_ffff;
            end else begin
              tcj_r <= 32'h8000_0000; t_r <= 32'h8000_0000;
            end
            ctx_r   <= C_DCJ;
            state_r <= S_D_T2;
          end else begin
            state_r <= S_DIVT;
          end
        end
        S_DIVT: if (op_fire) begin
          tcj_r   <= clamp32(div_rsp.value);
          t_r     <= clamp32(div_rsp.value);
          ctx_r   <= C_DCJ;
          state_r <= S_D_T2;
        end
        S_D_T2:  if (op_fire) begin t2_r <= mul_rsp.value; state_r <= S_D_T3; end
        S_D_T3:  if (op_fire) begin t3_r <= mul_rsp.value; state_r <= S_D_JT3; end
        S_D_JT3: if (op_fire) begin s_r <= mul_rsp.value; state_r <= S_D_DIV6; end
        S_D_DIV6: if (op_fire) begin s_r <= d6_quot; state_r <= S_D_AT2; end
        S_D_AT2: if (op_fire) begin
          s_r     <= sadd(s_r, half(mul_rsp.value));
          state_r <= S_D_VT;
        end
        S_D_VT: if (op_fire) begin
          fx_r    <= fx_new;
          state_r <= S_D_RET;
        end
        S_D_RET: begin
          unique case (ctx_r)
            C_DCJ: begin
              dacc_r <= sadd(ext(l_r), -fx_r);
              if (sadd(ext(l_r), -fx_r) < 0) begin
                t_r <= '0; ctx_r <= C_F0; state_r <= S_D_T2;
              end else begin
                t_r <= tcj_r; ctx_r <= C_V1; state_r <= S_V_T2;
              end
            end
            C_F0: begin
              if (fx_r > 0) begin
                res_vel_r <= '0; res_ph_r <= PhaseJerk; res_err_r <= ErrRange;
                state_r   <= S_FIN;
              end else begin
                t_r <= tcj_r; ctx_r <= C_FT; state_r <= S_D_T2;
              end
            end
            C_FT: begin
              if (fx_r < 0) begin
                res_vel_r <= '0; res_ph_r <= PhaseJerk; res_err_r <= ErrRange;
                state_r   <= S_FIN;
              end else begin
                lo_r <= '0; up_r <= tcj_r; iter_r <= '0; state_r <= S_BIS;
              end
            end
            C_MID: begin
              // stop on tolerance or at the iteration cap, keep last midpoint
              if ((fx_r < EpsS && fx_r > -EpsS) || iter_r == IterMax) begin
                ctx_r <= C_VB; state_r <= S_V_T2;
              end else begin
                if (fx_r > 0) up_r <= t_r;
                else lo_r <= t_r;
                state_r <= S_BIS;
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_BIS: begin
          t_r     <= mid_rnd[32:1];
          iter_r  <= iter_r + 1'b1;
          ctx_r   <= C_MID;
          state_r <= S_D_T2;
        end
        S_V_T2:  if (op_fire) begin t2_r <= mul_rsp.value; state_r <= S_V_JT2; end
        S_V_JT2: if (op_fire) begin s_r <= half(mul_rsp.value); state_r <= S_V_AT; end
        S_V_AT:  if (op_fire) begin s_r <= v_new; state_r <= S_V_RET; end
        S_V_RET: begin
          if (ctx_r == C_VB) begin
            res_vel_r <= clamp32(s_r); res_ph_r <= PhaseJerk; res_err_r <= ErrOk;
            state_r   <= S_FIN;
          end else begin
            v1_r    <= s_r;
            state_r <= S_DS1;
          end
        end
        S_DS1: if (op_fire) begin s_r <= mul_rsp.value; state_r <= S_DS2; end
        S_DS2: if (op_fire) begin s_r <= disc_new; state_r <= S_DS3; end
        S_DS3: begin
          if (s_r <= 0) begin
            res_vel_r <= '0; res_ph_r <= PhaseStopped; res_err_r <= ErrOk;
            state_r   <= S_FIN;
          end else if (s_r >= DiscMax) begin
            res_vel_r <= 32'h7fff_ffff; res_ph_r <= PhaseAccel; res_err_r <= ErrOk;
            state_r   <= S_FIN;
          end else begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: if (op_fire) begin
          res_vel_r <= sq_root; res_ph_r <= PhaseAccel; res_err_r <= ErrOk;
          state_r   <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_vel_r   <= res_vel_r;
            out_ph_r    <= res_ph_r;
            out_err_r   <= res_err_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_vel_r;
  assign out_tuser  = {out_err_r, out_ph_r};

endmodule
